### src/ttpf_pkg.sv
// ============================================================================
// ttpf_pkg: shared types and constants of the trajectory turn-point filter
// Register indexes, reset values, the front-to-back command word and the
// configuration bundle.
// ============================================================================
package ttpf_pkg;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LON_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_TURN   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [31:0] LON_SCALE_RESET  = 32'd186763113;
    localparam logic [31:0] LAT_SCALE_RESET  = 32'd186763113;
    localparam logic [15:0] MIN_STEP_RESET   = 16'd800;
    localparam logic [15:0] SHORT_STEP_RESET = 16'd8000;
    localparam logic [14:0] COS_TURN_RESET   = 15'd23170;

    // Track phase of a fix when it enters
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_ONE  = 2'd1,
        PH_MANY = 2'd2
    } phase_t;

    // Classified fix handed from front to back
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [31:0] dy;
        logic               fin;
        phase_t             phase;
        logic [15:0]        idx;
    } cmd_t;

    // Configuration bundle
    typedef struct packed {
        logic [31:0] lon_scale;
        logic [31:0] lat_scale;
        logic [15:0] min_step;
        logic [15:0] short_step;
        logic [14:0] cos_turn;
    } cfg_t;

endpackage

### src/ttpf_front.sv
// ============================================================================
// ttpf_front: fix intake and classification
// Track phase and index, coordinate differences against the previous fix.
// ============================================================================
module ttpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in_lon,
    input  logic signed [30:0] in_lat,
    input  logic               in_fin,
    input  logic               q_ready,
    output logic               q_push,
    output ttpf_pkg::cmd_t     q_cmd
);
    import ttpf_pkg::*;

    logic signed [31:0] prev_lon_reg;
    logic signed [30:0] prev_lat_reg;
    phase_t             phase_reg, phase_next;
    logic [15:0]        seen_reg, seen_next;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb
    begin
        q_cmd.dx    = {in_lon[31], in_lon} - {prev_lon_reg[31], prev_lon_reg};
        q_cmd.dy    = {in_lat[30], in_lat} - {prev_lat_reg[30], prev_lat_reg};
        q_cmd.fin   = in_fin;
        q_cmd.phase = phase_reg;
        q_cmd.idx   = seen_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        if (q_push)
        begin
            if (in_fin)
            begin
                phase_next = PH_NONE;
                seen_next  = '0;
            end
            else
            begin
                phase_next = (phase_reg == PH_NONE) ? PH_ONE : PH_MANY;
                seen_next  = seen_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NONE;
            seen_reg     <= '0;
            prev_lon_reg <= '0;
            prev_lat_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            // hold the last fix of an open track
            if (q_push && !in_fin)
            begin
                prev_lon_reg <= in_lon;
                prev_lat_reg <= in_lat;
            end
        end
    end

endmodule

### src/ttpf_fifo.sv
// ============================================================================
// ttpf_fifo: command queue
// Short first-in first-out buffer between front and back.
// ============================================================================
module ttpf_fifo #(
    parameter int DEPTH = ttpf_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttpf_pkg::cmd_t push_data,
    output logic           ready,
    input  logic           pop,
    output logic           pop_valid,
    output ttpf_pkg::cmd_t pop_data
);
    import ttpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue overfilled");

endmodule

### src/ttpf_back.sv
// ============================================================================
// ttpf_back: step scaling and keep decision
// Sequencer around one shared signed 33x33 multiplier; output register.
// ============================================================================
module ttpf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ttpf_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  ttpf_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_index,
    output logic           out_keep,
    output logic           out_end
);
    import ttpf_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE      = 4'b0001,
        B_CALC      = 4'b0010,
        B_EMIT_MID  = 4'b0100,
        B_EMIT_LAST = 4'b1000
    } bstate_t;

    // Sequencer steps: each issues one product and absorbs the previous one
    localparam logic [4:0] ST_LON    = 5'd0;
    localparam logic [4:0] ST_LAT    = 5'd1;
    localparam logic [4:0] ST_XSQ    = 5'd2;
    localparam logic [4:0] ST_YSQ    = 5'd3;
    localparam logic [4:0] ST_DOTX   = 5'd4;
    localparam logic [4:0] ST_DOTY   = 5'd5;
    localparam logic [4:0] ST_MIN    = 5'd6;
    localparam logic [4:0] ST_SHORT  = 5'd7;
    localparam logic [4:0] ST_COS    = 5'd8;
    localparam logic [4:0] ST_P_LL   = 5'd9;
    localparam logic [4:0] ST_P_LH   = 5'd10;
    localparam logic [4:0] ST_P_HL   = 5'd11;
    localparam logic [4:0] ST_P_HH   = 5'd12;
    localparam logic [4:0] ST_L_LL   = 5'd13;
    localparam logic [4:0] ST_L_LH   = 5'd14;
    localparam logic [4:0] ST_L_HH   = 5'd15;
    localparam logic [4:0] ST_R_0    = 5'd16;
    localparam logic [4:0] ST_R_1    = 5'd17;
    localparam logic [4:0] ST_R_2    = 5'd18;
    localparam logic [4:0] ST_R_END  = 5'd19;
    localparam logic [4:0] ST_DECIDE = 5'd20;

    bstate_t            state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    cmd_t               cur_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic signed [23:0] sx_reg, sy_reg, prev_sx_reg, prev_sy_reg;
    logic [46:0]        d2sq_reg, prev_dsq_reg;
    logic signed [47:0] dot_reg;
    logic [31:0]        mn_reg, sh_reg;
    logic [29:0]        c2_reg;
    logic [93:0]        p_reg;
    logic [123:0]       l_reg, r_reg;
    logic               keep_reg, keep_next;

    logic [32:0]        dx_mag;
    logic [31:0]        dy_mag;
    logic               finish, out_free, out_load;
    logic [15:0]        load_idx;
    logic               load_keep, load_end;
    logic               too_close, too_short, sharp;

    logic               out_valid_reg;
    logic [15:0]        out_index_reg;
    logic               out_keep_reg, out_end_reg;

    // round magnitude half away from zero, saturate, restore sign
    function automatic logic signed [23:0] round_sat(input logic [63:0] p, input logic neg);
        logic [40:0] q;
        logic [22:0] m;
        q = {1'b0, p[63:24]} + {40'd0, p[23]};
        m = (q > 41'h7FFFFF) ? 23'h7FFFFF : q[22:0];
        round_sat = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign dx_mag   = cur_reg.dx[32] ? (~cur_reg.dx + 33'd1) : cur_reg.dx;
    assign dy_mag   = cur_reg.dy[31] ? (~cur_reg.dy + 32'd1) : cur_reg.dy;
    assign out_free = !out_valid_reg || out_ready;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_LON:
            begin
                mul_a = {1'b0, dx_mag[31:0]};
                mul_b = {1'b0, cfg.lon_scale};
            end
            ST_LAT:
            begin
                mul_a = {1'b0, dy_mag};
                mul_b = {1'b0, cfg.lat_scale};
            end
            ST_XSQ:
            begin
                mul_a = {{9{sx_reg[23]}}, sx_reg};
                mul_b = {{9{sx_reg[23]}}, sx_reg};
            end
            ST_YSQ:
            begin
                mul_a = {{9{sy_reg[23]}}, sy_reg};
                mul_b = {{9{sy_reg[23]}}, sy_reg};
            end
            ST_DOTX:
            begin
                mul_a = {{9{prev_sx_reg[23]}}, prev_sx_reg};
                mul_b = {{9{sx_reg[23]}}, sx_reg};
            end
            ST_DOTY:
            begin
                mul_a = {{9{prev_sy_reg[23]}}, prev_sy_reg};
                mul_b = {{9{sy_reg[23]}}, sy_reg};
            end
            ST_MIN:
            begin
                mul_a = {17'd0, cfg.min_step};
                mul_b = {17'd0, cfg.min_step};
            end
            ST_SHORT:
            begin
                mul_a = {17'd0, cfg.short_step};
                mul_b = {17'd0, cfg.short_step};
            end
            ST_COS:
            begin
                mul_a = {18'd0, cfg.cos_turn};
                mul_b = {18'd0, cfg.cos_turn};
            end
            ST_P_LL:
            begin
                mul_a = {9'd0, prev_dsq_reg[23:0]};
                mul_b = {9'd0, d2sq_reg[23:0]};
            end
            ST_P_LH:
            begin
                mul_a = {9'd0, prev_dsq_reg[23:0]};
                mul_b = {10'd0, d2sq_reg[46:24]};
            end
            ST_P_HL:
            begin
                mul_a = {10'd0, prev_dsq_reg[46:24]};
                mul_b = {9'd0, d2sq_reg[23:0]};
            end
            ST_P_HH:
            begin
                mul_a = {10'd0, prev_dsq_reg[46:24]};
                mul_b = {10'd0, d2sq_reg[46:24]};
            end
            ST_L_LL:
            begin
                mul_a = {9'd0, dot_reg[23:0]};
                mul_b = {9'd0, dot_reg[23:0]};
            end
            ST_L_LH:
            begin
                mul_a = {9'd0, dot_reg[23:0]};
                mul_b = {10'd0, dot_reg[46:24]};
            end
            ST_L_HH:
            begin
                mul_a = {10'd0, dot_reg[46:24]};
                mul_b = {10'd0, dot_reg[46:24]};
            end
            ST_R_0:
            begin
                mul_a = {1'b0, p_reg[31:0]};
                mul_b = {3'd0, c2_reg};
            end
            ST_R_1:
            begin
                mul_a = {1'b0, p_reg[63:32]};
                mul_b = {3'd0, c2_reg};
            end
            ST_R_2:
            begin
                mul_a = {3'd0, p_reg[93:64]};
                mul_b = {3'd0, c2_reg};
            end
            default: ;
        endcase
    end

    // keep decision from finished sums
    always_comb
    begin
        too_close = (prev_dsq_reg < {15'd0, mn_reg}) || (d2sq_reg < {15'd0, mn_reg});
        too_short = (prev_dsq_reg < {15'd0, sh_reg}) || (d2sq_reg < {15'd0, sh_reg});
        sharp     = dot_reg[47] || (l_reg < r_reg);
        keep_next = !too_close && !(sharp && too_short);
    end

    // sequencer control
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_pop    = 1'b0;
        finish     = 1'b0;
        out_load   = 1'b0;
        load_idx   = cur_reg.idx;
        load_keep  = 1'b1;
        load_end   = cur_reg.fin;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = (cmd.phase == PH_NONE) ? B_EMIT_LAST : B_CALC;
                end
            end
            B_CALC:
            begin
                if (cur_reg.phase == PH_ONE && step_reg == ST_DOTY)
                begin
                    finish     = 1'b1;
                    step_next  = '0;
                    state_next = cur_reg.fin ? B_EMIT_LAST : B_IDLE;
                end
                else if (step_reg == ST_DECIDE)
                begin
                    finish     = 1'b1;
                    step_next  = '0;
                    state_next = B_EMIT_MID;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            B_EMIT_MID:
            begin
                load_idx  = cur_reg.idx - 16'd1;
                load_keep = keep_reg;
                load_end  = 1'b0;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = cur_reg.fin ? B_EMIT_LAST : B_IDLE;
                end
            end
            B_EMIT_LAST:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // datapath: multiply, absorb the previous product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (state_reg == B_CALC)
        begin
            case (step_reg)
                ST_LAT:    sx_reg   <= round_sat(prod_reg[63:0], cur_reg.dx[32]);
                ST_XSQ:    sy_reg   <= round_sat(prod_reg[63:0], cur_reg.dy[31]);
                ST_YSQ:    d2sq_reg <= prod_reg[46:0];
                ST_DOTX:   d2sq_reg <= d2sq_reg + prod_reg[46:0];
                ST_DOTY:   dot_reg  <= prod_reg[47:0];
                ST_MIN:    dot_reg  <= dot_reg + prod_reg[47:0];
                ST_SHORT:  mn_reg   <= prod_reg[31:0];
                ST_COS:    sh_reg   <= prod_reg[31:0];
                ST_P_LL:   c2_reg   <= prod_reg[29:0];
                ST_P_LH:   p_reg    <= {46'd0, prod_reg[47:0]};
                ST_P_HL:   p_reg    <= p_reg + {22'd0, prod_reg[47:0], 24'd0};
                ST_P_HH:   p_reg    <= p_reg + {22'd0, prod_reg[47:0], 24'd0};
                ST_L_LL:   p_reg    <= p_reg + {prod_reg[45:0], 48'd0};
                ST_L_LH:   l_reg    <= {46'd0, prod_reg[47:0], 30'd0};
                ST_L_HH:   l_reg    <= l_reg + {21'd0, prod_reg[47:0], 55'd0};
                ST_R_0:    l_reg    <= l_reg + {prod_reg[45:0], 78'd0};
                ST_R_1:    r_reg    <= {62'd0, prod_reg[61:0]};
                ST_R_2:    r_reg    <= r_reg + {30'd0, prod_reg[61:0], 32'd0};
                ST_R_END:  r_reg    <= r_reg + {prod_reg[59:0], 64'd0};
                ST_DECIDE: keep_reg <= keep_next;
                default: ;
            endcase
        end
        // advance the step history once this fix is done
        if (finish)
        begin
            prev_sx_reg  <= sx_reg;
            prev_sy_reg  <= sy_reg;
            prev_dsq_reg <= d2sq_reg;
        end
        if (out_load)
        begin
            out_index_reg <= load_idx;
            out_keep_reg  <= load_keep;
            out_end_reg   <= load_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_keep  = out_keep_reg;
    assign out_end   = out_end_reg;

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_CALC) |-> (step_reg == '0))
        else $error("step counter running outside calculation");

    a_decide_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CALC && step_reg == ST_DECIDE) |=> (state_reg == B_EMIT_MID))
        else $error("decision not followed by its result");

    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_EMIT_MID || state_reg == B_EMIT_LAST) && !out_free)
        |=> $stable(state_reg))
        else $error("result state left while output register busy");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != B_IDLE))
        else $error("popped command not taken up");

endmodule

### src/trajectory_turn_point_filter.sv
// ============================================================================
// trajectory_turn_point_filter: keep/drop decisions for a track of GPS fixes
// Configuration registers, front classifier, command queue, back sequencer.
// ============================================================================
// Each accepted word is one fix (longitude, latitude in 1e-7 degree, tlast on
// the final fix of a track). The front part tags the fix with its position
// in the track and its coordinate differences and queues it; up to
// QUEUE_DEPTH fixes wait there while the back part works. The back part
// scales each step to millimetres and decides the middle fix of every pair
// of steps, all on one shared signed 33x33 multiplier that runs its products
// one per cycle. Work per fix follows that sequence: the first fix of a track
// is only picked up and emitted, the second runs the steps up to ST_DOTY,
// every later fix all 21 sequencer steps plus command pickup and result load.
// A final fix in phase PH_MANY gives two result words: the decision for the
// fix before it, then its own keep with tlast. Results leave through a
// registered output stage, so the queue keeps filling while m_axis_tready is
// low. Point indices wrap at 65536 without restarting the track. Write the
// configuration only while the block is idle; there is no read-back.
// ============================================================================
module trajectory_turn_point_filter #(
    parameter int QUEUE_DEPTH = ttpf_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [ttpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,
    // fix stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [63:0]                      s_axis_tdata,   // longitude[31:0], latitude[62:32]
    input  logic                             s_axis_tlast,   // final_point
    // decision stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // point_index[15:0], keep[16]
    output logic                             m_axis_tlast    // end_of_track
);
    import ttpf_pkg::*;

    cfg_t        cfg_reg;
    logic        q_push, q_ready, q_pop, q_valid;
    cmd_t        q_in, q_out;
    logic [15:0] res_index;
    logic        res_keep;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lon_scale  <= LON_SCALE_RESET;
            cfg_reg.lat_scale  <= LAT_SCALE_RESET;
            cfg_reg.min_step   <= MIN_STEP_RESET;
            cfg_reg.short_step <= SHORT_STEP_RESET;
            cfg_reg.cos_turn   <= COS_TURN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LON_SCALE:  cfg_reg.lon_scale  <= cfg_data;
                REG_LAT_SCALE:  cfg_reg.lat_scale  <= cfg_data;
                REG_MIN_STEP:   cfg_reg.min_step   <= cfg_data[15:0];
                REG_SHORT_STEP: cfg_reg.short_step <= cfg_data[15:0];
                REG_COS_TURN:   cfg_reg.cos_turn   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // classify incoming fixes
    ttpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_lon   (s_axis_tdata[31:0]),
        .in_lat   (s_axis_tdata[62:32]),
        .in_fin   (s_axis_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    // decouple intake from the multiplier sequence
    ttpf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    // scale steps, decide, drive the output register
    ttpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (q_out),
        .cmd_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (res_index),
        .out_keep  (res_keep),
        .out_end   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, res_keep, res_index};

endmodule
